// ----- src/rsc_pkg.sv -----
// Shared types and constants of the ray sample compositor.
package rsc_pkg;

   localparam logic [16:0] ONE_Q16         = 17'h10000;
   localparam logic [23:0] SUM_MAX         = 24'hFFFFFF;
   localparam int unsigned DEPTH_LIMIT_BIT = 20;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [1:0] MODE_WEIGHT_FIRST = 2'd0;
   localparam logic [1:0] MODE_ATTEN_FIRST  = 2'd1;
   localparam logic [1:0] MODE_EXP          = 2'd2;

   typedef struct packed {
      logic        first_sample;
      logic [15:0] sample_red;
      logic [15:0] sample_green;
      logic [15:0] sample_blue;
      logic [15:0] sample_alpha;
      logic [15:0] step_length;
   } rsc_req_type;

   typedef struct packed {
      logic [23:0] out_red;
      logic [23:0] out_green;
      logic [23:0] out_blue;
      logic [23:0] out_alpha;
      logic [16:0] out_transmittance;
   } rsc_rsp_type;

   typedef struct packed {
      logic        first_sample;
      logic [15:0] sample_red;
      logic [15:0] sample_green;
      logic [15:0] sample_blue;
      logic [31:0] ah;
      logic [16:0] atten_factor;
   } rsc_item_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_DEPTH,
      BK_LOOKUP,
      BK_WEIGHT,
      BK_COLOR,
      BK_COMMIT
   } rsc_back_state_type;

endpackage

// ----- src/rsc_front.sv -----
// Front end: accepts samples, forms a*h and the linear attenuation factor.
module rsc_front import rsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  rsc_req_type  req_data,
   output logic         item_push,
   output rsc_item_type item_data,
   input  logic         item_full
);

   logic        stage_valid_ff;
   logic        stage_valid_in;
   logic        accept;
   logic        first_ff;
   logic [15:0] red_ff;
   logic [15:0] green_ff;
   logic [15:0] blue_ff;
   logic [31:0] ah_ff;

   assign full      = stage_valid_ff && item_full;
   assign accept    = push && !full;
   assign item_push = stage_valid_ff && !item_full;

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (item_push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= req_data.first_sample;
         red_ff   <= req_data.sample_red;
         green_ff <= req_data.sample_green;
         blue_ff  <= req_data.sample_blue;
         ah_ff    <= 32'(req_data.sample_alpha) * 32'(req_data.step_length);
      end
   end

   // clamp 1 - a*h at zero
   always_comb begin
      item_data.first_sample = first_ff;
      item_data.sample_red   = red_ff;
      item_data.sample_green = green_ff;
      item_data.sample_blue  = blue_ff;
      item_data.ah           = ah_ff;
      if (ah_ff >= 32'(ONE_Q16)) begin
         item_data.atten_factor = '0;
      end else begin
         item_data.atten_factor = 17'(32'(ONE_Q16) - ah_ff);
      end
   end

endmodule

// ----- src/rsc_queue.sv -----
// Short queue of classified samples between front and back end.
module rsc_queue import rsc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsc_item_type in_data,
   output logic         full,
   input  logic         pop,
   output rsc_item_type out_data,
   output logic         empty
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   rsc_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   count_ff;
   logic [PTR_W:0]   count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign out_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- src/rsc_back.sv -----
// Back end: sequencer that attenuates, weights and accumulates one sample at a time.
module rsc_back import rsc_pkg::*; #(
   parameter int unsigned EXP_TABLE_ENTRIES = 256,
   parameter int unsigned COLOR_FRAC_BITS   = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  logic         item_empty,
   input  rsc_item_type item_data,
   output logic         item_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsc_rsp_type  rsp_data
);

   localparam int unsigned IDX_W      = (EXP_TABLE_ENTRIES > 1) ? $clog2(EXP_TABLE_ENTRIES) : 1;
   localparam int unsigned IDX_PROD_W = DEPTH_LIMIT_BIT + IDX_W + 1;
   localparam int unsigned SHIFT_UP   = (COLOR_FRAC_BITS >= 16) ? COLOR_FRAC_BITS - 16 : 0;
   localparam int unsigned SHIFT_DOWN = (COLOR_FRAC_BITS < 16) ? 16 - COLOR_FRAC_BITS : 0;
   localparam int unsigned INC_W      = 32 + SHIFT_UP;

   // exp(-16k/N) in Q1.16 from y = k/N in Q30: Taylor series of e^y in Q30, invert,
   // square four times
   function automatic logic [16:0] exp_entry(input logic [63:0] y);
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] rem;
      logic [63:0] v;
      term = 64'h1 << 30;
      acc  = term;
      term = ((term * y) >> 30) / 64'd1;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd2;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd3;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd4;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd5;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd6;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd7;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd8;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd9;  acc = acc + term;
      term = ((term * y) >> 30) / 64'd10; acc = acc + term;
      term = ((term * y) >> 30) / 64'd11; acc = acc + term;
      term = ((term * y) >> 30) / 64'd12; acc = acc + term;
      term = ((term * y) >> 30) / 64'd13; acc = acc + term;
      term = ((term * y) >> 30) / 64'd14; acc = acc + term;
      term = ((term * y) >> 30) / 64'd15; acc = acc + term;
      term = ((term * y) >> 30) / 64'd16; acc = acc + term;
      term = ((term * y) >> 30) / 64'd17; acc = acc + term;
      term = ((term * y) >> 30) / 64'd18; acc = acc + term;
      term = ((term * y) >> 30) / 64'd19; acc = acc + term;
      term = ((term * y) >> 30) / 64'd20; acc = acc + term;
      term = ((term * y) >> 30) / 64'd21; acc = acc + term;
      term = ((term * y) >> 30) / 64'd22; acc = acc + term;
      term = ((term * y) >> 30) / 64'd23; acc = acc + term;
      term = ((term * y) >> 30) / 64'd24; acc = acc + term;
      term = ((term * y) >> 30) / 64'd25; acc = acc + term;
      term = ((term * y) >> 30) / 64'd26; acc = acc + term;
      term = ((term * y) >> 30) / 64'd27; acc = acc + term;
      term = ((term * y) >> 30) / 64'd28; acc = acc + term;
      term = ((term * y) >> 30) / 64'd29; acc = acc + term;
      term = ((term * y) >> 30) / 64'd30; acc = acc + term;
      // 2^60 / acc by restoring long division
      rem = '0;
      v   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], 1'(b == 60)};
         if (rem >= acc) begin
            rem  = rem - acc;
            v[b] = 1'b1;
         end
      end
      v = (v * v + (64'h1 << 29)) >> 30;
      v = (v * v + (64'h1 << 29)) >> 30;
      v = (v * v + (64'h1 << 29)) >> 30;
      v = (v * v + (64'h1 << 29)) >> 30;
      return 17'((v + (64'h1 << 13)) >> 14);
   endfunction

   // rescale a Q.16 increment to the sum format and add with saturation
   function automatic logic [23:0] sat_accum(input logic [23:0] sum, input logic [31:0] inc);
      logic [INC_W-1:0] scaled;
      logic [24:0]      total;
      scaled = (INC_W'(inc) << SHIFT_UP) >> SHIFT_DOWN;
      if (scaled > INC_W'(SUM_MAX)) begin
         scaled = INC_W'(SUM_MAX);
      end
      total = 25'(sum) + 25'(scaled);
      return total[24] ? SUM_MAX : total[23:0];
   endfunction

   logic [16:0] exp_rom [EXP_TABLE_ENTRIES];

   for (genvar k = 0; k < EXP_TABLE_ENTRIES; k++) begin : g_exp_rom
      localparam logic [63:0] Ratio = (64'(k) << 30) / 64'(EXP_TABLE_ENTRIES);
      localparam logic [16:0] Entry = exp_entry(Ratio);
      assign exp_rom[k] = Entry;
   end

   rsc_back_state_type state_ff;
   rsc_back_state_type state_in;
   logic               do_load;
   logic               do_commit;

   logic [1:0]         mode_ff;
   logic [16:0]        trans_ff;
   logic [16:0]        trans_in;
   logic [31:0]        depth_ff;
   logic [31:0]        depth_in;
   logic [23:0]        sum_ff [4];
   logic [23:0]        sum_in [4];
   logic [23:0]        sum_new [4];
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsc_rsp_type        rsp_data_ff;

   rsc_item_type       work_ff;
   logic [16:0]        t_old_ff;
   logic [16:0]        t_lin_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               beyond_ff;
   logic [16:0]        exp_ff;
   logic [31:0]        weight_ff;
   logic [31:0]        inc_ff [3];

   logic [16:0]        t_base;
   logic [31:0]        d_base;
   logic [32:0]        d_sum;
   logic [31:0]        d_sat;
   logic [33:0]        tf_prod;
   logic [16:0]        t_lin;
   logic [IDX_PROD_W-1:0] idx_prod;
   logic [16:0]        t_exp;
   logic [16:0]        weight_t;
   logic [16:0]        t_new;
   logic [48:0]        w_prod;
   logic [15:0]        color [3];
   logic [47:0]        c_prod [3];

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // restart applies before the sample is used
   assign t_base  = item_data.first_sample ? ONE_Q16 : trans_ff;
   assign d_base  = item_data.first_sample ? '0 : depth_ff;
   assign d_sum   = 33'(d_base) + 33'(item_data.ah);
   assign d_sat   = d_sum[32] ? '1 : d_sum[31:0];
   assign tf_prod = 34'(t_base) * 34'(item_data.atten_factor);
   assign t_lin   = 17'(tf_prod >> 16);

   assign idx_prod = IDX_PROD_W'(depth_ff[DEPTH_LIMIT_BIT-1:0])
                   * IDX_PROD_W'(EXP_TABLE_ENTRIES);
   assign t_exp    = beyond_ff ? '0 : exp_ff;

   always_comb begin
      unique case (mode_ff)
         MODE_ATTEN_FIRST: begin
            weight_t = t_lin_ff;
            t_new    = t_lin_ff;
         end
         MODE_EXP: begin
            weight_t = t_exp;
            t_new    = t_exp;
         end
         default: begin
            weight_t = t_old_ff;
            t_new    = t_lin_ff;
         end
      endcase
   end

   assign w_prod   = 49'(work_ff.ah) * 49'(weight_t);
   assign color[0] = work_ff.sample_red;
   assign color[1] = work_ff.sample_green;
   assign color[2] = work_ff.sample_blue;

   for (genvar i = 0; i < 3; i++) begin : g_color
      assign c_prod[i]  = 48'(color[i]) * 48'(weight_ff);
      assign sum_new[i] = sat_accum(sum_ff[i], inc_ff[i]);
   end
   assign sum_new[3] = sat_accum(sum_ff[3], weight_ff);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      item_pop  = 1'b0;
      do_load   = 1'b0;
      do_commit = 1'b0;
      unique case (state_ff)
         BK_LOAD: begin
            if (!item_empty) begin
               item_pop = 1'b1;
               do_load  = 1'b1;
               state_in = (mode_ff == MODE_EXP) ? BK_DEPTH : BK_WEIGHT;
            end
         end
         BK_DEPTH: begin
            state_in = BK_LOOKUP;
         end
         BK_LOOKUP: begin
            state_in = BK_WEIGHT;
         end
         BK_WEIGHT: begin
            state_in = BK_COLOR;
         end
         BK_COLOR: begin
            state_in = BK_COMMIT;
         end
         BK_COMMIT: begin
            // hold until the result slot is free or being drained
            if (!rsp_valid_ff || rsp_pop) begin
               do_commit = 1'b1;
               state_in  = BK_LOAD;
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_comb begin
      trans_in = trans_ff;
      depth_in = depth_ff;
      for (int i = 0; i < 4; i++) begin
         sum_in[i] = sum_ff[i];
      end
      if (do_load) begin
         trans_in = t_base;
         depth_in = d_sat;
         if (item_data.first_sample) begin
            for (int i = 0; i < 4; i++) begin
               sum_in[i] = '0;
            end
         end
      end
      if (state_ff == BK_WEIGHT) begin
         trans_in = t_new;
      end
      if (do_commit) begin
         for (int i = 0; i < 4; i++) begin
            sum_in[i] = sum_new[i];
         end
      end
      if (do_commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         mode_ff      <= MODE_WEIGHT_FIRST;
         trans_ff     <= ONE_Q16;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         trans_ff     <= trans_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 4; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         work_ff  <= item_data;
         t_old_ff <= t_base;
         t_lin_ff <= t_lin;
      end
      if (state_ff == BK_DEPTH) begin
         idx_ff    <= IDX_W'(idx_prod >> DEPTH_LIMIT_BIT);
         beyond_ff <= |depth_ff[31:DEPTH_LIMIT_BIT];
      end
      if (state_ff == BK_LOOKUP) begin
         exp_ff <= exp_rom[idx_ff];
      end
      if (state_ff == BK_WEIGHT) begin
         weight_ff <= w_prod[47:16];
      end
      if (state_ff == BK_COLOR) begin
         for (int i = 0; i < 3; i++) begin
            inc_ff[i] <= c_prod[i][47:16];
         end
      end
      if (do_commit) begin
         rsp_data_ff.out_red           <= sum_new[0];
         rsp_data_ff.out_green         <= sum_new[1];
         rsp_data_ff.out_blue          <= sum_new[2];
         rsp_data_ff.out_alpha         <= sum_new[3];
         rsp_data_ff.out_transmittance <= trans_ff;
      end
   end

endmodule

// ----- src/ray_sample_compositor.sv -----
// Top level of the front-to-back ray sample compositor.
//
// Use: the caster writes samples into a queue-like input (push/full/req_data)
// and reads composited RGBA plus transmittance from a queue-like output
// (empty/pop/rsp_data). A sample transfers when push is high and full is low;
// a result transfers when pop is high and empty is low. One result per sample.
// The mode register (csr_wr_en/csr_wr_data) must be written only while the
// block is idle; the user must keep to this, as the block has no check for it.
//
// The back-end sequencer carries the transmittance through a multiply and back
// into the next sample, so it handles one sample at a time; exponential mode
// adds a depth-to-index multiply and a table read.
// Buffering: the front stage plus a 2-entry queue take up to three samples
// ahead of the sequencer, so the caster keeps pushing while a result waits.
// Stall: when the reader does not pop, the finished result holds and the
// sequencer waits; full rises once the front stage and queue fill.
// Reset: clears mode to 0, transmittance to 1.0, depth and sums to zero, and
// empties all queues. No clearing pass; the exp table is constant logic.
module ray_sample_compositor import rsc_pkg::*; #(
   parameter int unsigned EXP_TABLE_ENTRIES = 256,
   parameter int unsigned COLOR_FRAC_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  rsc_req_type req_data,
   output logic        empty,
   input  logic        pop,
   output rsc_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   // classified samples moving from front end to queue to sequencer
   logic         front_push;
   rsc_item_type front_item;
   logic         queue_full;
   logic         queue_pop;
   logic         queue_empty;
   rsc_item_type queue_item;

   // accept and classify: a*h and the clamped linear factor
   rsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .item_push (front_push),
      .item_data (front_item),
      .item_full (queue_full)
   );

   // decouple the front end from the sequencer
   rsc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .in_data  (front_item),
      .full     (queue_full),
      .pop      (queue_pop),
      .out_data (queue_item),
      .empty    (queue_empty)
   );

   // attenuate, weight and accumulate; owns the ray state and result register
   rsc_back #(
      .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES),
      .COLOR_FRAC_BITS   (COLOR_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .item_empty  (queue_empty),
      .item_data   (queue_item),
      .item_pop    (queue_pop),
      .rsp_empty   (empty),
      .rsp_pop     (pop),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- src/rsc_checker.sv -----
// Port-level assertions for the ray sample compositor, bound to the top level.
module rsc_checker import rsc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        full,
   input logic        empty,
   input logic        pop,
   input rsc_rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input reports full after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished before transfer");

   a_trans_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.out_transmittance <= ONE_Q16))
      else $error("transmittance above 1.0");

endmodule

bind ray_sample_compositor rsc_checker u_rsc_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
